/* rtl/core/memstg_pkg.sv */
// Shared types and constants for the memory stage: operation codes, cop0
// register numbers, exception codes, fault flag bit indices and the access flag bundle.
// No dependencies.
package memstg_pkg;

    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LB   = 4'd1;
    localparam logic [3:0] OP_LBU  = 4'd2;
    localparam logic [3:0] OP_LH   = 4'd3;
    localparam logic [3:0] OP_LHU  = 4'd4;
    localparam logic [3:0] OP_LW   = 4'd5;
    localparam logic [3:0] OP_SB   = 4'd6;
    localparam logic [3:0] OP_SH   = 4'd7;
    localparam logic [3:0] OP_SW   = 4'd8;
    localparam logic [3:0] OP_MTC0 = 4'd9;
    localparam logic [3:0] OP_RFE  = 4'd10;

    localparam logic [4:0] CP0_STATUS = 5'd12;
    localparam logic [4:0] CP0_CAUSE  = 5'd13;

    localparam logic [3:0] EXC_INT  = 4'h0;
    localparam logic [3:0] EXC_ADEL = 4'h4;
    localparam logic [3:0] EXC_ADES = 4'h5;
    localparam logic [3:0] EXC_IBE  = 4'h6;
    localparam logic [3:0] EXC_DBE  = 4'h7;
    localparam logic [3:0] EXC_SYS  = 4'h8;
    localparam logic [3:0] EXC_BP   = 4'h9;
    localparam logic [3:0] EXC_RI   = 4'hA;
    localparam logic [3:0] EXC_CPU  = 4'hB;
    localparam logic [3:0] EXC_OV   = 4'hC;

    localparam int FLT_IF_MISALIGN = 0;
    localparam int FLT_IF_VIOL     = 1;
    localparam int FLT_IF_BUS      = 2;
    localparam int FLT_SYSCALL     = 4;
    localparam int FLT_BREAK       = 5;
    localparam int FLT_ILLEGAL     = 6;
    localparam int FLT_COP         = 7;

    typedef struct packed {
        logic data_access;
        logic is_write;
        logic load_err;
        logic store_err;
    } mem_flags_t;

endpackage

/* rtl/core/memstg_align.sv */
// Byte lane enables, load alignment with extension, and address fault checks.
// Depends on memstg_pkg.
module memstg_align (
    input  logic [3:0]              operation,
    input  logic [31:0]             address,
    input  logic [31:0]             read_data,
    input  logic                    user_mode,
    output logic [3:0]              byte_enables,
    output logic [31:0]             load_data,
    output memstg_pkg::mem_flags_t  flags
);
    import memstg_pkg::*;

    logic        is_load;
    logic        is_store;
    logic        is_byte;
    logic        is_half;
    logic        is_word;
    logic [1:0]  offset;
    logic [31:0] lane_sel;
    logic        misaligned;
    logic        violation;

    assign is_load  = (operation >= OP_LB) && (operation <= OP_LW);
    assign is_store = (operation >= OP_SB) && (operation <= OP_SW);
    assign is_byte  = (operation == OP_LB) || (operation == OP_LBU) || (operation == OP_SB);
    assign is_half  = (operation == OP_LH) || (operation == OP_LHU) || (operation == OP_SH);
    assign is_word  = (operation == OP_LW) || (operation == OP_SW);
    assign offset   = address[1:0];

    always_comb
    begin
        priority if (is_byte)
        begin
            byte_enables = 4'b0001 << offset;
        end
        else if (is_half)
        begin
            byte_enables = (offset == 2'd0) ? 4'b0011 :
                           (offset == 2'd2) ? 4'b1100 : 4'b0000;
        end
        else if (is_word && (offset == 2'd0))
        begin
            byte_enables = 4'b1111;
        end
        else
        begin
            byte_enables = 4'b0000;
        end
    end

    always_comb
    begin
        priority if (byte_enables[0])
        begin
            lane_sel = read_data;
        end
        else if (byte_enables[1])
        begin
            lane_sel = {8'b0, read_data[31:8]};
        end
        else if (byte_enables[2])
        begin
            lane_sel = {16'b0, read_data[31:16]};
        end
        else
        begin
            lane_sel = {24'b0, read_data[31:24]};
        end
    end

    always_comb
    begin
        priority if (operation == OP_LW)
        begin
            load_data = lane_sel;
        end
        else if ((operation == OP_LB) || (operation == OP_LBU))
        begin
            load_data = {{24{(operation == OP_LB) && lane_sel[7]}}, lane_sel[7:0]};
        end
        else if ((operation == OP_LH) || (operation == OP_LHU))
        begin
            load_data = {{16{(operation == OP_LH) && lane_sel[15]}}, lane_sel[15:0]};
        end
        else
        begin
            load_data = address;
        end
    end

    assign misaligned = (is_word && (offset != 2'd0)) || (is_half && offset[0]);
    assign violation  = user_mode && address[31];

    assign flags.data_access = is_load || is_store;
    assign flags.is_write    = is_store;
    assign flags.load_err    = is_load && (misaligned || violation);
    assign flags.store_err   = is_store && (misaligned || violation);

endmodule

/* rtl/core/memstg_except.sv */
// Exception code priority, cause word composition and cop0 write strobes.
// Depends on memstg_pkg.
module memstg_except (
    input  logic [3:0]              operation,
    input  logic [31:0]             address,
    input  logic [4:0]              cop0_register,
    input  logic [7:0]              fault_flags,
    input  logic                    interrupt_request,
    input  logic                    data_bus_error,
    input  logic [5:0]              hw_interrupts,
    input  logic [31:0]             cause_current,
    input  logic                    in_delay_slot,
    input  memstg_pkg::mem_flags_t  flags,
    output logic                    address_error,
    output logic                    exception_request,
    output logic [31:0]             cause_word,
    output logic [31:0]             cause_write_value,
    output logic                    write_cause,
    output logic                    write_status
);
    import memstg_pkg::*;

    logic [3:0] exc_code;

    always_comb
    begin
        priority if (interrupt_request)
        begin
            exc_code = EXC_INT;
        end
        else if (flags.load_err || fault_flags[FLT_IF_MISALIGN] || fault_flags[FLT_IF_VIOL])
        begin
            exc_code = EXC_ADEL;
        end
        else if (flags.store_err)
        begin
            exc_code = EXC_ADES;
        end
        else if (fault_flags[FLT_IF_BUS])
        begin
            exc_code = EXC_IBE;
        end
        else if (data_bus_error)
        begin
            exc_code = EXC_DBE;
        end
        else if (fault_flags[FLT_SYSCALL])
        begin
            exc_code = EXC_SYS;
        end
        else if (fault_flags[FLT_BREAK])
        begin
            exc_code = EXC_BP;
        end
        else if (fault_flags[FLT_ILLEGAL])
        begin
            exc_code = EXC_RI;
        end
        else if (fault_flags[FLT_COP])
        begin
            exc_code = EXC_CPU;
        end
        else
        begin
            exc_code = EXC_OV;
        end
    end

    assign address_error     = flags.load_err || flags.store_err;
    assign exception_request = (fault_flags != 8'd0) || address_error || data_bus_error;

    assign cause_word = {in_delay_slot, 15'b0, hw_interrupts, cause_current[9:8],
                         2'b0, exc_code, 2'b0};

    assign cause_write_value = {cause_current[31:16], hw_interrupts, address[9:8],
                                cause_current[7:0]};

    assign write_cause  = (operation == OP_MTC0) && (cop0_register == CP0_CAUSE);
    assign write_status = (operation == OP_RFE) ||
                          ((operation == OP_MTC0) && (cop0_register == CP0_STATUS));

endmodule

/* rtl/core/mips_memory_stage_align_and_exception_unit.sv */
// Memory stage top level: input register, alignment and exception logic,
// result register. Depends on memstg_pkg, memstg_align, memstg_except.
// Throughput: one beat per cycle unless the output stalls; the input and
// result registers form a two-entry pipeline, so input stalls only when
// both hold beats and the output is stalled. Reset empties both
// registers (valids clear).
module mips_memory_stage_align_and_exception_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [3:0]  operation,
    input  logic [31:0] address,
    input  logic [31:0] read_data,
    input  logic        user_mode,
    input  logic [4:0]  cop0_register,
    input  logic [7:0]  fault_flags,
    input  logic        interrupt_request,
    input  logic        data_bus_error,
    input  logic [5:0]  hw_interrupts,
    input  logic [31:0] cause_current,
    input  logic        in_delay_slot,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [3:0]  byte_enables,
    output logic [31:0] load_data,
    output logic        data_access,
    output logic        is_write,
    output logic        address_error,
    output logic        exception_request,
    output logic [31:0] cause_word,
    output logic [31:0] cause_write_value,
    output logic        write_cause,
    output logic        write_status
);
    import memstg_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        res_load;
    logic        in_load;

    logic [3:0]  operation_reg;
    logic [31:0] address_reg;
    logic [31:0] read_data_reg;
    logic        user_mode_reg;
    logic [4:0]  cop0_register_reg;
    logic [7:0]  fault_flags_reg;
    logic        interrupt_request_reg;
    logic        data_bus_error_reg;
    logic [5:0]  hw_interrupts_reg;
    logic [31:0] cause_current_reg;
    logic        in_delay_slot_reg;

    mem_flags_t  acc_flags;
    logic [3:0]  be_c;
    logic [31:0] load_data_c;
    logic        address_error_c;
    logic        exception_request_c;
    logic [31:0] cause_word_c;
    logic [31:0] cause_write_value_c;
    logic        write_cause_c;
    logic        write_status_c;

    logic [3:0]  byte_enables_reg;
    logic [31:0] load_data_reg;
    logic        data_access_reg;
    logic        is_write_reg;
    logic        address_error_reg;
    logic        exception_request_reg;
    logic [31:0] cause_word_reg;
    logic [31:0] cause_write_value_reg;
    logic        write_cause_reg;
    logic        write_status_reg;

    assign res_load  = !res_valid_reg || !rsp_stall;
    assign in_load   = !in_valid_reg || res_load;
    assign req_stall = !in_load;

    assign in_valid_next  = in_load ? req_valid : in_valid_reg;
    assign res_valid_next = res_load ? in_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // capture the incoming beat
    always_ff @(posedge clk)
    begin
        if (in_load && req_valid)
        begin
            operation_reg         <= operation;
            address_reg           <= address;
            read_data_reg         <= read_data;
            user_mode_reg         <= user_mode;
            cop0_register_reg     <= cop0_register;
            fault_flags_reg       <= fault_flags;
            interrupt_request_reg <= interrupt_request;
            data_bus_error_reg    <= data_bus_error;
            hw_interrupts_reg     <= hw_interrupts;
            cause_current_reg     <= cause_current;
            in_delay_slot_reg     <= in_delay_slot;
        end
    end

    memstg_align u_align (
        .operation    (operation_reg),
        .address      (address_reg),
        .read_data    (read_data_reg),
        .user_mode    (user_mode_reg),
        .byte_enables (be_c),
        .load_data    (load_data_c),
        .flags        (acc_flags)
    );

    memstg_except u_except (
        .operation         (operation_reg),
        .address           (address_reg),
        .cop0_register     (cop0_register_reg),
        .fault_flags       (fault_flags_reg),
        .interrupt_request (interrupt_request_reg),
        .data_bus_error    (data_bus_error_reg),
        .hw_interrupts     (hw_interrupts_reg),
        .cause_current     (cause_current_reg),
        .in_delay_slot     (in_delay_slot_reg),
        .flags             (acc_flags),
        .address_error     (address_error_c),
        .exception_request (exception_request_c),
        .cause_word        (cause_word_c),
        .cause_write_value (cause_write_value_c),
        .write_cause       (write_cause_c),
        .write_status      (write_status_c)
    );

    // advance the result beat; hold while stalled
    always_ff @(posedge clk)
    begin
        if (res_load && in_valid_reg)
        begin
            byte_enables_reg      <= be_c;
            load_data_reg         <= load_data_c;
            data_access_reg       <= acc_flags.data_access;
            is_write_reg          <= acc_flags.is_write;
            address_error_reg     <= address_error_c;
            exception_request_reg <= exception_request_c;
            cause_word_reg        <= cause_word_c;
            cause_write_value_reg <= cause_write_value_c;
            write_cause_reg       <= write_cause_c;
            write_status_reg      <= write_status_c;
        end
    end

    assign rsp_valid         = res_valid_reg;
    assign byte_enables      = byte_enables_reg;
    assign load_data         = load_data_reg;
    assign data_access       = data_access_reg;
    assign is_write          = is_write_reg;
    assign address_error     = address_error_reg;
    assign exception_request = exception_request_reg;
    assign cause_word        = cause_word_reg;
    assign cause_write_value = cause_write_value_reg;
    assign write_cause       = write_cause_reg;
    assign write_status      = write_status_reg;

endmodule

/* rtl/core/memstg_checker.sv */
// Port-level checks for the memory stage, bound to the top level.
// Depends on mips_memory_stage_align_and_exception_unit.
module memstg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [3:0]  byte_enables,
    input logic [31:0] load_data,
    input logic        data_access,
    input logic        is_write,
    input logic        address_error,
    input logic        exception_request,
    input logic [31:0] cause_word,
    input logic        write_cause,
    input logic        write_status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(load_data) && $stable(cause_word))
        else $error("result beat dropped or changed while stalled");

    a_lanes_need_access: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (byte_enables != 4'd0) |-> data_access)
        else $error("byte lanes enabled without a data access");

    a_addr_err_raises: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && address_error |-> exception_request && data_access)
        else $error("address error without exception request or access");

    a_cop0_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && write_cause |-> !write_status && !data_access && !is_write)
        else $error("cause write overlaps status write or data access");

    a_fill_two_deep: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled while result side can advance");

endmodule

bind mips_memory_stage_align_and_exception_unit memstg_checker u_memstg_checker (.*);
